FILE: sv/bkem_pkg.sv
// bkem_pkg: shared constants, item kind codes and control structs for the
// approximate bitap matcher. No dependencies.
package bkem_pkg;

    localparam int PATTERN_BITS_DEF     = 64;
    localparam int MAX_ERRORS_LIMIT_DEF = 4;
    localparam int ALPHABET_SIZE_DEF    = 128;

    localparam int KIND_W = 2;
    localparam int SYM_W  = 7;
    localparam int CFG_W  = 3;

    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATTERN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NEW_TEXT = 2'd3;

    localparam logic [CFG_W-1:0] MAX_ERRORS_RESET = 3'd1;

    // Mask table control, driven by the issue/execute stages
    typedef struct packed {
        logic load;   // read issued for the item entering execute
        logic fire;   // execute stage completes its item
        logic wr_en;  // write back the updated mask
        logic clr;    // empty the whole table
    } mask_ctrl_t;

    // Row bank control
    typedef struct packed {
        logic step;   // advance all rows by one text symbol
        logic zero;   // clear all rows
    } row_ctrl_t;

endpackage

FILE: sv/bkem_mask_mem.sv
// bkem_mask_mem: symbol mask table, one synchronous memory with per-entry
// valid bits and a one-entry write-forwarding register. Depends on bkem_pkg.
module bkem_mask_mem
    import bkem_pkg::*;
#(
    parameter int PATTERN_BITS  = PATTERN_BITS_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int ADDR_W        = $clog2(ALPHABET_SIZE)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mask_ctrl_t              ctrl,
    input  logic [ADDR_W-1:0]       rd_addr,
    input  logic [PATTERN_BITS-1:0] wr_data,
    output logic [PATTERN_BITS-1:0] entry
);

    logic [PATTERN_BITS-1:0]  mem [ALPHABET_SIZE];
    logic [PATTERN_BITS-1:0]  rd_data_reg;
    logic [PATTERN_BITS-1:0]  rd_data;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ALPHABET_SIZE-1:0] valid_reg;
    logic                     fwd_valid_reg;
    logic [ADDR_W-1:0]        fwd_addr_reg;
    logic [PATTERN_BITS-1:0]  fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
        if (ctrl.fire && ctrl.wr_en) begin
            mem[addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else if (ctrl.fire) begin
            fwd_valid_reg <= ctrl.wr_en;
            if (ctrl.clr) begin
                valid_reg <= '0;
            end else if (ctrl.wr_en) begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fire && ctrl.wr_en) begin
            fwd_addr_reg <= addr_reg;
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

    // Take the last write when it hit this entry after the read was issued
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == addr_reg)) begin
            entry = fwd_data_reg;
        end else if (valid_reg[addr_reg]) begin
            entry = rd_data;
        end else begin
            entry = '0;
        end
    end

endmodule

FILE: sv/bkem_row_unit.sv
// bkem_row_unit: exact row and error rows of the k-error bitap recurrence,
// with the end-of-pattern test on the selected row. Depends on bkem_pkg.
module bkem_row_unit
    import bkem_pkg::*;
#(
    parameter int PATTERN_BITS     = PATTERN_BITS_DEF,
    parameter int MAX_ERRORS_LIMIT = MAX_ERRORS_LIMIT_DEF,
    parameter int ROWS             = MAX_ERRORS_LIMIT + 1,
    parameter int ROW_W            = $clog2(ROWS),
    parameter int LEN_W            = $clog2(PATTERN_BITS + 1),
    parameter int POS_W            = $clog2(PATTERN_BITS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  row_ctrl_t               ctrl,
    input  logic [PATTERN_BITS-1:0] mask,
    input  logic [ROW_W-1:0]        sel,
    input  logic [LEN_W-1:0]        pattern_len,
    output logic                    hit
);

    logic [PATTERN_BITS-1:0] row_reg  [ROWS];
    logic [PATTERN_BITS-1:0] row_next [ROWS];
    logic [LEN_W-1:0]        len_m1;

    always_comb begin
        row_next[0] = ((row_reg[0] << 1) | PATTERN_BITS'(1)) & mask;
        for (int d = 1; d < ROWS; d++) begin
            row_next[d] = row_reg[d-1] | (row_next[d-1] << 1) | (row_reg[d-1] << 1)
                        | PATTERN_BITS'(1) | ((row_reg[d] << 1) & mask);
        end
    end

    assign len_m1 = pattern_len - LEN_W'(1);
    assign hit    = (pattern_len != '0) && row_next[sel][len_m1[POS_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < ROWS; d++) begin
                row_reg[d] <= '0;
            end
        end else if (ctrl.zero) begin
            for (int d = 0; d < ROWS; d++) begin
                row_reg[d] <= '0;
            end
        end else if (ctrl.step) begin
            for (int d = 0; d < ROWS; d++) begin
                row_reg[d] <= row_next[d];
            end
        end
    end

endmodule

FILE: sv/bitap_k_error_match.sv
// bitap_k_error_match: top level of the k-error approximate bitap matcher.
// Depends on bkem_pkg, bkem_mask_mem and bkem_row_unit.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_kind[1:0], s_symbol[6:0]
//  m_        out        m_valid / m_ready    m_match_now, m_found_so_far
//  cfg_      in         cfg_valid/cfg_ready  cfg_max_errors[2:0]
//
// One item per cycle sustained while the output register takes text results. An item
// is issued to the mask table read port in the cycle of its transfer and completes
// in the execute stage, when the registered read data is back; a text result sits in
// the output register from the cycle after that. Only text symbols give a result.
// Reset is synchronous, active low: it clears the valid bits of the mask table
// at once (no clearing pass), the rows, the pattern length and the flags, and
// sets max_errors to 1.
// A stalled result blocks only a following text item in execute; pattern,
// clear and new-text items keep flowing while a result waits.
module bitap_k_error_match
    import bkem_pkg::*;
#(
    parameter int PATTERN_BITS     = PATTERN_BITS_DEF,
    parameter int MAX_ERRORS_LIMIT = MAX_ERRORS_LIMIT_DEF,
    parameter int ALPHABET_SIZE    = ALPHABET_SIZE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [SYM_W-1:0]  s_symbol,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_match_now,
    output logic              m_found_so_far,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_max_errors
);

    localparam int ROWS   = MAX_ERRORS_LIMIT + 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int LEN_W  = $clog2(PATTERN_BITS + 1);
    localparam int POS_W  = $clog2(PATTERN_BITS);
    localparam int ADDR_W = $clog2(ALPHABET_SIZE);

    // Execute stage
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic              s1_in_range_reg;
    logic              s1_fire;
    logic              s_accept;

    // Architectural state
    logic [LEN_W-1:0]  pattern_len_reg;
    logic              found_reg;
    logic [CFG_W-1:0]  max_err_reg;

    // Output register
    logic              m_valid_reg;
    logic              m_match_reg;
    logic              m_found_reg;

    logic [SYM_W:0]          sym_ext;
    logic                    in_range;
    logic [ADDR_W-1:0]       rd_addr;
    logic [PATTERN_BITS-1:0] entry;
    logic [PATTERN_BITS-1:0] mask;
    logic [PATTERN_BITS-1:0] wr_data;
    logic                    len_room;
    logic [ROW_W-1:0]        sel;
    logic                    hit;
    logic                    is_text;
    mask_ctrl_t              mask_ctrl;
    row_ctrl_t               row_ctrl;

    // Hold a text item in execute while the output register is full
    assign is_text  = (s1_kind_reg == KIND_TEXT);
    assign s1_fire  = s1_valid_reg && (!is_text || !m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    assign sym_ext  = {1'b0, s_symbol};
    assign in_range = (int'(sym_ext) < ALPHABET_SIZE);
    assign rd_addr  = sym_ext[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg     <= s_kind;
            s1_in_range_reg <= in_range;
        end
    end

    // Pattern symbols past the row width take no position and set no bit
    assign len_room = (pattern_len_reg < LEN_W'(PATTERN_BITS));
    assign mask     = s1_in_range_reg ? entry : '0;
    assign wr_data  = entry | (PATTERN_BITS'(1) << pattern_len_reg[POS_W-1:0]);

    always_comb begin
        mask_ctrl.load  = s_accept;
        mask_ctrl.fire  = s1_fire;
        mask_ctrl.wr_en = (s1_kind_reg == KIND_PATTERN) && s1_in_range_reg && len_room;
        mask_ctrl.clr   = (s1_kind_reg == KIND_CLEAR);
    end

    always_comb begin
        row_ctrl.step = s1_fire && is_text;
        row_ctrl.zero = s1_fire && ((s1_kind_reg == KIND_CLEAR)
                                    || (s1_kind_reg == KIND_NEW_TEXT));
    end

    // Saturate the tolerated error count to the deepest row
    always_comb begin
        if (int'(max_err_reg) > MAX_ERRORS_LIMIT) begin
            sel = ROW_W'(MAX_ERRORS_LIMIT);
        end else begin
            sel = ROW_W'(max_err_reg);
        end
    end

    bkem_mask_mem #(
        .PATTERN_BITS  (PATTERN_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W)
    ) u_mask_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mask_ctrl),
        .rd_addr (rd_addr),
        .wr_data (wr_data),
        .entry   (entry)
    );

    bkem_row_unit #(
        .PATTERN_BITS     (PATTERN_BITS),
        .MAX_ERRORS_LIMIT (MAX_ERRORS_LIMIT),
        .ROWS             (ROWS),
        .ROW_W            (ROW_W),
        .LEN_W            (LEN_W),
        .POS_W            (POS_W)
    ) u_row_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (row_ctrl),
        .mask        (mask),
        .sel         (sel),
        .pattern_len (pattern_len_reg),
        .hit         (hit)
    );

    // Pattern length and sticky found flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg <= '0;
            found_reg       <= 1'b0;
        end else if (s1_fire) begin
            unique case (s1_kind_reg)
                KIND_CLEAR: begin
                    pattern_len_reg <= '0;
                    found_reg       <= 1'b0;
                end
                KIND_PATTERN: begin
                    if (len_room) begin
                        pattern_len_reg <= pattern_len_reg + LEN_W'(1);
                    end
                end
                KIND_TEXT: begin
                    found_reg <= found_reg | hit;
                end
                KIND_NEW_TEXT: begin
                    found_reg <= 1'b0;
                end
                default: begin
                    found_reg <= found_reg;
                end
            endcase
        end
    end

    // Output register: load on a completing text symbol, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (row_ctrl.step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_ctrl.step) begin
            m_match_reg <= hit;
            m_found_reg <= found_reg | hit;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_now    = m_match_reg;
    assign m_found_so_far = m_found_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_err_reg <= MAX_ERRORS_RESET;
        end else if (cfg_valid) begin
            max_err_reg <= cfg_max_errors;
        end
    end

endmodule
